// ===== sv/rqt_pkg.sv =====
// rqt_pkg: shared types and constants of the resource quota tracker.
// No dependencies; imported by every rqt module.
package rqt_pkg;

	localparam int NUM_RES          = 4;
	localparam int RES_W            = 2;
	localparam int SAMPLE_COUNT_DEF = 10;
	localparam int SAMPLE_W         = 7;
	localparam int SAMPLE_MAX       = 100;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 32;

	localparam logic [31:0] CPU_LIMIT     = 32'd100;
	localparam logic [31:0] CPU_THRESHOLD = 32'd80;
	localparam logic [RES_W-1:0] RES_CPU  = 2'd1;

	typedef enum logic [2:0] {
		KIND_ALLOC   = 3'd0,
		KIND_RELEASE = 3'd1,
		KIND_QUERY   = 3'd2,
		KIND_STATS   = 3'd3,
		KIND_PEAK    = 3'd4,
		KIND_TICK    = 3'd5
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MEMORY_LIMIT   = 3'd0,
		REG_FLASH_LIMIT    = 3'd1,
		REG_NETWORK_LIMIT  = 3'd2,
		REG_CHECK_INTERVAL = 3'd3,
		REG_MONITOR_ENABLE = 3'd4
	} reg_idx_t;

	// configuration as seen by the datapath, thresholds precomputed
	typedef struct packed {
		logic [31:0] mem_quota;
		logic [31:0] flash_quota;
		logic [31:0] network_limit;
		logic [31:0] check_interval;
		logic        monitor_enable;
		logic [31:0] memory_thr;
		logic [31:0] flash_thr;
		logic [31:0] network_thr;
	} cfg_t;

	// one request as held in the input register
	typedef struct packed {
		kind_t       kind;
		logic [2:0]  resource;
		logic [31:0] amount;
	} op_t;

	// quota bank result for one request
	typedef struct packed {
		logic        ok;
		logic        over_release;
		logic        above_threshold;
		logic        sampled;
		logic [3:0]  high_mask;
		logic [31:0] used_count;
		logic [31:0] limit_value;
		logic [31:0] peak_count;
		logic [31:0] threshold_value;
	} qres_t;

endpackage

// ===== sv/rqt_cfg.sv =====
// rqt_cfg: configuration registers and their warning thresholds.
// Depends on rqt_pkg.
module rqt_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rqt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rqt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output rqt_pkg::cfg_t                   cfg
);
	import rqt_pkg::*;

	cfg_t cfg_q;

	// floor(x * 80 / 100) = 4*floor(x/5) + floor(4*(x mod 5)/5)
	function automatic logic [31:0] thr_of(input logic [31:0] x);
		logic [63:0] prod;
		logic [31:0] a;
		logic [34:0] a5;
		logic [2:0]  b;
		logic [1:0]  frac;
		prod = 64'(x) * 64'h0000_0000_CCCC_CCCD;
		// floor(x/5) = prod >> 34, at most 30 bits
		a    = {2'b00, prod[63:34]};
		a5   = {1'b0, a, 2'b00} + {3'b000, a};
		b    = 3'(35'(x) - a5);
		unique case (b)
			3'd2:    frac = 2'd1;
			3'd3:    frac = 2'd2;
			3'd4:    frac = 2'd3;
			default: frac = 2'd0;
		endcase
		return {a[29:0], 2'b00} + {30'd0, frac};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MEMORY_LIMIT: begin
					cfg_q.mem_quota  <= cfg_wdata;
					cfg_q.memory_thr <= thr_of(cfg_wdata);
				end
				REG_FLASH_LIMIT: begin
					cfg_q.flash_quota <= cfg_wdata;
					cfg_q.flash_thr   <= thr_of(cfg_wdata);
				end
				REG_NETWORK_LIMIT: begin
					cfg_q.network_limit <= cfg_wdata;
					cfg_q.network_thr   <= thr_of(cfg_wdata);
				end
				REG_CHECK_INTERVAL: cfg_q.check_interval <= cfg_wdata;
				REG_MONITOR_ENABLE: cfg_q.monitor_enable <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/rqt_cpu_ring.sv =====
// rqt_cpu_ring: cpu sample ring, running sum, mean and tick gating.
// Depends on rqt_pkg.
module rqt_cpu_ring #(
	parameter int SAMPLE_COUNT = rqt_pkg::SAMPLE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rqt_pkg::cfg_t                 cfg,
	input  logic                          tick_req,
	input  logic                          commit,
	input  logic [31:0]                   now_ms,
	input  logic [rqt_pkg::SAMPLE_W-1:0]  cpu_sample,
	output logic                          tick_ok,
	output logic [rqt_pkg::SAMPLE_W-1:0]  avg_next
);
	import rqt_pkg::*;

	localparam int SLOT_W  = $clog2(SAMPLE_COUNT);
	localparam int SUM_MAX = SAMPLE_COUNT * SAMPLE_MAX;
	localparam int SUM_W   = $clog2(SUM_MAX + 1);
	localparam int SH      = 24;
	localparam int RECIP   = ((1 << SH) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
	localparam int RECIP_W = SH + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;

	logic [SAMPLE_W-1:0] samples_q [SAMPLE_COUNT];
	logic [SLOT_W-1:0]   slot_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [31:0]         last_check_q;

	logic [SAMPLE_W-1:0] clamped;
	logic [SUM_W-1:0]    sum_next;
	logic [PROD_W-1:0]   prod;
	logic [31:0]         elapsed;
	logic                take;

	assign elapsed = now_ms - last_check_q;
	assign tick_ok = tick_req && cfg.monitor_enable && (elapsed >= cfg.check_interval);
	assign take    = commit && tick_ok;

	assign clamped  = (cpu_sample > SAMPLE_W'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX) : cpu_sample;
	assign sum_next = sum_q - SUM_W'(samples_q[slot_q]) + SUM_W'(clamped);
	// mean by reciprocal multiply; exact over the whole sum range
	assign prod     = PROD_W'(sum_next) * PROD_W'(RECIP);
	assign avg_next = tick_ok ? prod[SH +: SAMPLE_W] : avg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SAMPLE_COUNT; i++) begin
				samples_q[i] <= '0;
			end
			slot_q       <= '0;
			sum_q        <= '0;
			avg_q        <= '0;
			last_check_q <= '0;
		end else if (take) begin
			samples_q[slot_q] <= clamped;
			slot_q            <= (slot_q == SLOT_W'(SAMPLE_COUNT - 1)) ? '0 : slot_q + 1'b1;
			sum_q             <= sum_next;
			avg_q             <= prod[SH +: SAMPLE_W];
			last_check_q      <= now_ms;
		end
	end

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(SAMPLE_COUNT - 1))
		else $error("sample slot out of range");
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_W'(SUM_MAX))
		else $error("sample sum exceeds ring maximum");
	a_avg_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (avg_q <= SAMPLE_W'(SAMPLE_MAX)) && (last_check_q == $past(now_ms)))
		else $error("tick left bad mean or timestamp");

endmodule

// ===== sv/rqt_quota.sv =====
// rqt_quota: used and peak counters of the four resources and request decode.
// Depends on rqt_pkg.
module rqt_quota (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rqt_pkg::cfg_t                 cfg,
	input  rqt_pkg::op_t                  op,
	input  logic                          commit,
	input  logic                          tick_ok,
	input  logic [rqt_pkg::SAMPLE_W-1:0]  avg_next,
	output rqt_pkg::qres_t                res
);
	import rqt_pkg::*;

	logic [31:0] used_q [NUM_RES];
	logic [31:0] peak_q [NUM_RES];
	logic [31:0] used_nx [NUM_RES];
	logic [31:0] peak_nx [NUM_RES];
	logic [31:0] lim [NUM_RES];
	logic [31:0] thr [NUM_RES];

	logic [RES_W-1:0] r;
	logic             valid;
	logic [31:0]      used_cur;
	logic [32:0]      sum33;
	logic             fits;
	logic [31:0]      avg32;

	assign r        = op.resource[RES_W-1:0];
	assign valid    = !op.resource[2];
	assign lim[0]   = cfg.mem_quota;
	assign lim[1]   = CPU_LIMIT;
	assign lim[2]   = cfg.flash_quota;
	assign lim[3]   = cfg.network_limit;
	assign thr[0]   = cfg.memory_thr;
	assign thr[1]   = CPU_THRESHOLD;
	assign thr[2]   = cfg.flash_thr;
	assign thr[3]   = cfg.network_thr;
	assign used_cur = used_q[r];
	assign sum33    = {1'b0, used_cur} + {1'b0, op.amount};
	assign fits     = sum33 <= {1'b0, lim[r]};
	assign avg32    = 32'(avg_next);

	always_comb begin
		used_nx = used_q;
		peak_nx = peak_q;
		res     = '0;
		if (op.kind == KIND_TICK) begin
			if (tick_ok) begin
				used_nx[RES_CPU] = avg32;
				if (avg32 > peak_q[RES_CPU]) begin
					peak_nx[RES_CPU] = avg32;
				end
				res.ok      = 1'b1;
				res.sampled = 1'b1;
				for (int i = 0; i < NUM_RES; i++) begin
					res.high_mask[i] = used_nx[i] >= thr[i];
				end
			end
		end else if (valid) begin
			unique case (op.kind)
				KIND_ALLOC: begin
					if (fits) begin
						used_nx[r] = sum33[31:0];
						if (sum33[31:0] > peak_q[r]) begin
							peak_nx[r] = sum33[31:0];
						end
						res.ok = 1'b1;
					end
				end
				KIND_RELEASE: begin
					if (op.amount > used_cur) begin
						used_nx[r]       = '0;
						res.over_release = 1'b1;
					end else begin
						used_nx[r] = used_cur - op.amount;
					end
					res.ok = 1'b1;
				end
				KIND_QUERY: res.ok = fits;
				KIND_STATS: res.ok = 1'b1;
				KIND_PEAK: begin
					peak_nx[r] = used_cur;
					res.ok     = 1'b1;
				end
				default: ;
			endcase
		end
		if (valid) begin
			res.above_threshold = used_nx[r] >= thr[r];
			res.used_count      = used_nx[r];
			res.limit_value     = lim[r];
			res.peak_count      = peak_nx[r];
			res.threshold_value = thr[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RES; i++) begin
				used_q[i] <= '0;
				peak_q[i] <= '0;
			end
		end else if (commit) begin
			used_q <= used_nx;
			peak_q <= peak_nx;
		end
	end

endmodule

// ===== sv/resource_quota_tracker_core.sv =====
// resource_quota_tracker_core: top level of the resource quota tracker.
// Items pass the input register, then the result register, which drives m_tvalid.
// Throughput: one item per cycle unless the result stalls; update is one combinational pass.
// Backpressure: s_tready falls only while the input register is full and the result stalls.
// Reset (arst_n low, async): counters, peaks, cpu ring, timestamp, config, valid flags clear.
// Depends on rqt_pkg, rqt_cfg, rqt_cpu_ring, rqt_quota.
module resource_quota_tracker_core #(
	parameter int SAMPLE_COUNT = rqt_pkg::SAMPLE_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [rqt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rqt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [71:0]                     s_tdata,  // amount[31:0], now_ms[63:32], cpu_sample[70:64]
	input  logic [5:0]                      s_tuser,  // kind[2:0], resource[5:3]
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// ok[0], over_release[1], above_threshold[2], sampled[3], high_mask[7:4],
	// used_count[39:8], limit_value[71:40], peak_count[103:72],
	// threshold_value[135:104], cpu_average[142:136]
	output logic [143:0]                    m_tdata
);
	import rqt_pkg::*;

	// input register
	logic                valid_s1;
	op_t                 op_s1;
	logic [31:0]         now_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	// result register
	logic                valid_s2;
	logic [143:0]        data_s2;

	logic                advance;
	cfg_t                cfg;
	logic                tick_ok;
	logic [SAMPLE_W-1:0] avg_next;
	qres_t               qres;

	// item in the input register moves on whenever the result register is free or drains;
	// state is committed on that same edge so the next item sees it
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1.kind     <= kind_t'(s_tuser[2:0]);
			op_s1.resource <= s_tuser[5:3];
			op_s1.amount   <= s_tdata[31:0];
			now_s1         <= s_tdata[63:32];
			sample_s1      <= s_tdata[70:64];
		end
	end

	rqt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// tick gating, sample ring and mean
	rqt_cpu_ring #(
		.SAMPLE_COUNT (SAMPLE_COUNT)
	) u_cpu_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.tick_req   (op_s1.kind == KIND_TICK),
		.commit     (advance),
		.now_ms     (now_s1),
		.cpu_sample (sample_s1),
		.tick_ok    (tick_ok),
		.avg_next   (avg_next)
	);

	// used / peak counters and per-request result
	rqt_quota u_quota (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.op       (op_s1),
		.commit   (advance),
		.tick_ok  (tick_ok),
		.avg_next (avg_next),
		.res      (qres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {1'b0, avg_next, qres.threshold_value, qres.peak_count,
				qres.limit_value, qres.used_count, qres.high_mask, qres.sampled,
				qres.above_threshold, qres.over_release, qres.ok};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input held off without a stalled result");
	a_sampled_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (data_s2[3] || data_s2[1] || (data_s2[7:4] != 4'd0))) |-> data_s2[0])
		else $error("result flag set without ok");
	a_mask_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (data_s2[7:4] != 4'd0)) |-> data_s2[3])
		else $error("high mask outside an accepted tick");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for resource_quota_tracker_core, with its own quota predictor.
// Depends on rqt_pkg and the core; stimulus is directed first, then random per config phase.
module tb;
	import rqt_pkg::*;

	localparam int RING_DEPTH     = SAMPLE_COUNT_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int END_SETTLE     = 8;	// settle time after the last phase, before the final verdict
	localparam int ITEMS_PER_PHASE = 200;
	localparam int RANDOM_PHASES  = 6;

	// resource codes as carried in the item, including two out-of-range ones
	localparam logic [2:0] RSC_MEMORY  = 3'd0;
	localparam logic [2:0] RSC_CPU     = {1'b0, RES_CPU};
	localparam logic [2:0] RSC_FLASH   = 3'd2;
	localparam logic [2:0] RSC_NETWORK = 3'd3;
	localparam logic [2:0] RSC_BAD_LO  = 3'd4;
	localparam logic [2:0] RSC_BAD_HI  = 3'd7;

	// kind codes the block has no operation for
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	localparam logic [63:0] WARN_PCT = 64'd80;
	localparam logic [63:0] FULL_PCT = 64'd100;

	// one request item, fields as in s_tdata / s_tuser
	typedef struct {
		logic [2:0]          kind;
		logic [2:0]          resource;
		logic [31:0]         amount;
		logic [31:0]         now_ms;
		logic [SAMPLE_W-1:0] cpu_sample;
	} quota_req_t;

	// one result item, laid out to match m_tdata (first member is the top bit)
	typedef struct packed {
		logic                spare;
		logic [SAMPLE_W-1:0] cpu_average;
		logic [31:0]         threshold_value;
		logic [31:0]         peak_count;
		logic [31:0]         limit_value;
		logic [31:0]         used_count;
		logic [3:0]          high_mask;
		logic                sampled;
		logic                above_threshold;
		logic                over_release;
		logic                ok;
	} quota_reply_t;

	// ---------------------------------------------------------------- DUT ports
	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata   = '0;	// amount[31:0], now_ms[63:32], cpu_sample[70:64]
	logic [5:0]   s_tuser   = '0;	// kind[2:0], resource[5:3]
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	// ok[0], over_release[1], above_threshold[2], sampled[3], high_mask[7:4],
	// used_count[39:8], limit_value[71:40], peak_count[103:72],
	// threshold_value[135:104], cpu_average[142:136]
	logic [143:0] m_tdata;

	resource_quota_tracker_core #(
		.SAMPLE_COUNT(RING_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor state
	// register copies, written alongside the real register writes
	logic [31:0] lim_memory, lim_flash, lim_network, tick_interval;
	logic        monitor_on;
	// quota and cpu ring copies
	logic [31:0]         used_q [NUM_RES];
	logic [31:0]         peak_q [NUM_RES];
	logic [SAMPLE_W-1:0] cpu_ring [RING_DEPTH];
	int unsigned         ring_pos;
	logic [31:0]         last_tick_ms;

	quota_req_t   pending_reqs [$];	// items waiting for the driver
	quota_reply_t replies_due [$];	// predicted results, oldest first

	// bench bookkeeping
	int          mismatches   = 0;
	int          results_seen = 0;
	int          stall_cycles = 0;
	int unsigned gap_left     = 0;
	int unsigned burst_left   = 0;
	int          flow_mode    = 0;	// 0 steady, 1 sender gaps, 2 gaps and receiver stalls
	logic        req_taken    = 1'b0;
	logic [15:0] ready_bits   = 16'hffff;
	int unsigned pattern_age  = 0;
	logic [31:0] sim_ms       = 32'h0000_1000;
	quota_req_t   next_req;
	quota_reply_t want_rep, got_rep;

	function automatic logic [31:0] quota_limit(input logic [1:0] r);
		case (r)
			RSC_MEMORY[1:0]: return lim_memory;
			RES_CPU:         return CPU_LIMIT;
			RSC_FLASH[1:0]:  return lim_flash;
			default:         return lim_network;
		endcase
	endfunction

	// 80 percent of the limit on a 64-bit product, truncated
	function automatic logic [31:0] warn_level(input logic [1:0] r);
		logic [63:0] prod;
		prod = {32'd0, quota_limit(r)} * WARN_PCT;
		return 32'(prod / FULL_PCT);
	endfunction

	function automatic logic [31:0] cpu_mean();
		logic [31:0] sum;
		sum = '0;
		for (int i = 0; i < RING_DEPTH; i++)
			sum += cpu_ring[i];
		return sum / RING_DEPTH;
	endfunction

	// Updates the quota copy for one accepted item and returns what the block should send.
	function automatic quota_reply_t apply_request(input logic [2:0] kind,
		input logic [2:0] res, input logic [31:0] amount, input logic [31:0] now_ms,
		input logic [SAMPLE_W-1:0] sample);
		quota_reply_t rep;
		logic [1:0]   r;
		logic         known;
		logic [32:0]  total;
		logic [31:0]  elapsed;
		logic [31:0]  avg;
		rep     = '0;
		r       = res[1:0];
		known   = (res < NUM_RES);
		total   = {1'b0, used_q[r]} + {1'b0, amount};
		elapsed = now_ms - last_tick_ms;
		if (kind == KIND_TICK) begin
			// resource code plays no part in accepting a tick
			if (monitor_on && elapsed >= tick_interval) begin
				last_tick_ms = now_ms;
				if (ring_pos >= RING_DEPTH)
					ring_pos = 0;
				cpu_ring[ring_pos] = (sample > SAMPLE_MAX) ? SAMPLE_W'(SAMPLE_MAX) : sample;
				ring_pos = (ring_pos + 1) % RING_DEPTH;
				avg = cpu_mean();
				used_q[RES_CPU] = avg;
				if (avg > peak_q[RES_CPU])
					peak_q[RES_CPU] = avg;
				for (int i = 0; i < NUM_RES; i++)
					if (used_q[i] >= warn_level(2'(i)))
						rep.high_mask[i] = 1'b1;
				rep.ok      = 1'b1;
				rep.sampled = 1'b1;
			end
		end else if (known) begin
			case (kind)
				KIND_ALLOC: begin
					// compared on 33 bits, so a wrapping sum fails
					if (total <= {1'b0, quota_limit(r)}) begin
						used_q[r] = total[31:0];
						if (used_q[r] > peak_q[r])
							peak_q[r] = used_q[r];
						rep.ok = 1'b1;
					end
				end
				KIND_RELEASE: begin
					if (amount > used_q[r]) begin
						used_q[r]        = '0;
						rep.over_release = 1'b1;
					end else begin
						used_q[r] = used_q[r] - amount;
					end
					rep.ok = 1'b1;
				end
				KIND_QUERY: rep.ok = (total <= {1'b0, quota_limit(r)});
				KIND_STATS: rep.ok = 1'b1;
				KIND_PEAK: begin
					peak_q[r] = used_q[r];
					rep.ok    = 1'b1;
				end
				default: ;
			endcase
		end
		if (known) begin
			rep.above_threshold = (used_q[r] >= warn_level(r));
			rep.used_count      = used_q[r];
			rep.limit_value     = quota_limit(r);
			rep.peak_count      = peak_q[r];
			rep.threshold_value = warn_level(r);
		end
		avg = cpu_mean();
		rep.cpu_average = avg[SAMPLE_W-1:0];
		return rep;
	endfunction

	// ---------------------------------------------------------------- driver
	// Falling edge: offer the next queued item once the current one has gone.
	// Bursts of random length are separated by random gaps unless the flow is steady.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || req_taken)) begin
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				next_req = pending_reqs.pop_front();
				s_tdata  <= {1'b0, next_req.cpu_sample, next_req.now_ms, next_req.amount};
				s_tuser  <= {next_req.resource, next_req.kind};
				s_tvalid <= 1'b1;
				if (burst_left != 0) begin
					burst_left = burst_left - 1;
				end else if (flow_mode != 0) begin
					burst_left = $urandom_range(0, 23);
					gap_left   = $urandom_range(1, 8);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: always ready below flow mode 2; else walks a 16-bit ready pattern, reloaded whenever pattern_age wraps.
	// Mostly-ready patterns dominate; now and then a sparse one gives long stalls.
	always @(negedge clk) begin
		if (flow_mode < 2) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ready_bits[0];
			ready_bits = {ready_bits[0], ready_bits[15:1]};
			pattern_age++;
			if (pattern_age == 48) begin
				pattern_age = 0;
				case ($urandom_range(0, 3))
					0:       ready_bits = 16'hffff;
					1:       ready_bits = 16'($urandom() & $urandom());
					default: ready_bits = 16'($urandom() | $urandom());
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %0h got %0h", results_seen, name, want, got);
		end
	endtask

	// Rising edge: compare the outgoing item first, then predict for the incoming one,
	// so an expectation never meets a result in the cycle it was made.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				if (replies_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: unexpected, data %0h", results_seen, m_tdata);
				end else begin
					want_rep = replies_due.pop_front();
					got_rep  = quota_reply_t'(m_tdata);
					check_field("ok", 32'(want_rep.ok), 32'(got_rep.ok));
					check_field("over_release", 32'(want_rep.over_release),
						32'(got_rep.over_release));
					check_field("above_threshold", 32'(want_rep.above_threshold),
						32'(got_rep.above_threshold));
					check_field("sampled", 32'(want_rep.sampled), 32'(got_rep.sampled));
					check_field("high_mask", 32'(want_rep.high_mask), 32'(got_rep.high_mask));
					check_field("used_count", want_rep.used_count, got_rep.used_count);
					check_field("limit_value", want_rep.limit_value, got_rep.limit_value);
					check_field("peak_count", want_rep.peak_count, got_rep.peak_count);
					check_field("threshold_value", want_rep.threshold_value,
						got_rep.threshold_value);
					check_field("cpu_average", 32'(want_rep.cpu_average),
						32'(got_rep.cpu_average));
				end
				results_seen++;
			end
			if (s_tvalid && s_tready)
				replies_due.push_back(apply_request(s_tuser[2:0], s_tuser[5:3],
					s_tdata[31:0], s_tdata[63:32], s_tdata[70:64]));
			// watchdog: only counts while work is outstanding and nothing moves
			if ((pending_reqs.size() != 0 || s_tvalid || replies_due.size() != 0) &&
				!(s_tvalid && s_tready) && !(m_tvalid && m_tready))
				stall_cycles++;
			else
				stall_cycles = 0;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	task automatic queue_req(input logic [2:0] kind, input logic [2:0] res,
		input logic [31:0] amount, input logic [31:0] now_ms,
		input logic [SAMPLE_W-1:0] sample);
		quota_req_t item;
		item.kind       = kind;
		item.resource   = res;
		item.amount     = amount;
		item.now_ms     = now_ms;
		item.cpu_sample = sample;
		pending_reqs.push_back(item);
	endtask

	// register write at the next rising edge; the predictor copy follows at once
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MEMORY_LIMIT:   lim_memory    = val;
			REG_FLASH_LIMIT:    lim_flash     = val;
			REG_NETWORK_LIMIT:  lim_network   = val;
			REG_CHECK_INTERVAL: tick_interval = val;
			REG_MONITOR_ENABLE: monitor_on    = val[0];
			default: ;
		endcase
	endtask

	// sender holds off until every queued item has gone and every result is back
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || s_tvalid || replies_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_all(input logic [31:0] mem, input logic [31:0] flash,
		input logic [31:0] net, input logic [31:0] interval, input logic enable);
		write_reg(REG_MEMORY_LIMIT, mem);
		write_reg(REG_FLASH_LIMIT, flash);
		write_reg(REG_NETWORK_LIMIT, net);
		write_reg(REG_CHECK_INTERVAL, interval);
		write_reg(REG_MONITOR_ENABLE, {31'd0, enable});
	endtask

	// Mostly valid resources with amounts scaled to the current limit, so allocations
	// both fit and fail; a clock that creeps forward and sometimes hits the interval.
	function automatic quota_req_t random_req();
		quota_req_t  item;
		logic [31:0] lim;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 24)      item.kind = KIND_ALLOC;
		else if (pick < 44) item.kind = KIND_RELEASE;
		else if (pick < 58) item.kind = KIND_QUERY;
		else if (pick < 68) item.kind = KIND_STATS;
		else if (pick < 76) item.kind = KIND_PEAK;
		else if (pick < 97) item.kind = KIND_TICK;
		else                item.kind = $urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI;
		if ($urandom_range(0, 99) < 92)
			item.resource = 3'($urandom_range(RSC_MEMORY, RSC_NETWORK));
		else
			item.resource = 3'($urandom_range(RSC_BAD_LO, RSC_BAD_HI));
		lim = quota_limit(item.resource[1:0]);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: item.amount = $urandom_range(0, lim >> 3);
			4, 5:       item.amount = $urandom_range(0, lim >> 1);
			6:          item.amount = lim;
			7:          item.amount = $urandom();
			8:          item.amount = '0;
			default:    item.amount = lim - $urandom_range(0, 2);
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: sim_ms = sim_ms + $urandom_range(0, 40);
			6:                sim_ms = sim_ms + tick_interval;
			7:                sim_ms = sim_ms + tick_interval - 1;
			8:                sim_ms = $urandom();
			default: ;
		endcase
		item.now_ms = sim_ms;
		if ($urandom_range(0, 15) == 0)
			item.cpu_sample = SAMPLE_W'($urandom_range(SAMPLE_MAX + 1, 127));
		else
			item.cpu_sample = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
		return item;
	endfunction

	initial begin
		// predictor starts from the reset state
		lim_memory    = '0;
		lim_flash     = '0;
		lim_network   = '0;
		tick_interval = '0;
		monitor_on    = 1'b0;
		for (int i = 0; i < NUM_RES; i++) begin
			used_q[i] = '0;
			peak_q[i] = '0;
		end
		for (int i = 0; i < RING_DEPTH; i++)
			cpu_ring[i] = '0;
		ring_pos     = 0;
		last_tick_ms = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: all limits zero, monitoring off
		flow_mode = 2;
		queue_req(KIND_ALLOC, RSC_MEMORY, 32'd0, 32'd0, 7'd0);	// zero fits a zero limit
		queue_req(KIND_ALLOC, RSC_MEMORY, 32'd1, 32'd0, 7'd0);
		queue_req(KIND_TICK, RSC_CPU, 32'd0, 32'd100, 7'd50);	// refused, monitor off
		queue_req(KIND_STATS, RSC_NETWORK, 32'd0, 32'd0, 7'd0);
		wait_idle();

		write_all(32'd1000, 32'hffff_ffff, 32'd0, 32'd0, 1'b1);
		queue_req(KIND_ALLOC, RSC_MEMORY, 32'd600, 32'd0, 7'd0);
		queue_req(KIND_ALLOC, RSC_MEMORY, 32'd500, 32'd0, 7'd0);	// over the limit
		queue_req(KIND_QUERY, RSC_MEMORY, 32'd400, 32'd0, 7'd0);
		queue_req(KIND_ALLOC, RSC_MEMORY, 32'd400, 32'd0, 7'd0);	// exactly full
		queue_req(KIND_RELEASE, RSC_MEMORY, 32'd5000, 32'd0, 7'd0);	// over-release clamps
		queue_req(KIND_ALLOC, RSC_FLASH, 32'hffff_ffff, 32'd0, 7'd0);
		queue_req(KIND_ALLOC, RSC_FLASH, 32'd1, 32'd0, 7'd0);	// sum wraps 32 bits
		queue_req(KIND_ALLOC, RSC_NETWORK, 32'd0, 32'd0, 7'd0);
		queue_req(KIND_ALLOC, RSC_CPU, 32'd100, 32'd0, 7'd0);	// fixed cpu limit
		queue_req(KIND_PEAK, RSC_CPU, 32'd0, 32'd0, 7'd0);
		queue_req(KIND_RELEASE, RSC_CPU, 32'd30, 32'd0, 7'd0);
		queue_req(KIND_STATS, RSC_BAD_LO, 32'd0, 32'd0, 7'd0);
		queue_req(KIND_ALLOC, RSC_BAD_HI, 32'd5, 32'd0, 7'd0);
		queue_req(KIND_TICK, RSC_BAD_HI, 32'd0, 32'd1000, 7'd127);	// sample clamps to 100
		queue_req(KIND_TICK, RSC_MEMORY, 32'd0, 32'd1000, 7'd100);	// zero interval, same time
		queue_req(KIND_SPARE_LO, RSC_MEMORY, 32'd1, 32'd0, 7'd0);
		queue_req(KIND_SPARE_HI, RSC_CPU, 32'd1, 32'd0, 7'd0);
		wait_idle();

		// tick spacing at and across the interval, including the time wrap
		write_reg(REG_CHECK_INTERVAL, 32'd50);
		queue_req(KIND_TICK, RSC_CPU, 32'd0, 32'd1049, 7'd10);
		queue_req(KIND_TICK, RSC_CPU, 32'd0, 32'd1050, 7'd90);
		queue_req(KIND_TICK, RSC_CPU, 32'd0, 32'hffff_fff0, 7'd64);
		queue_req(KIND_TICK, RSC_CPU, 32'd0, 32'h0000_0022, 7'd33);
		wait_idle();

		// random phases, each with its own register setting and flow
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: write_all(32'd1000, 32'd5000, 32'd300, 32'd0, 1'b1);
				1: write_all($urandom_range(1, 50000), 32'hffff_ffff, 32'd0, 32'd20, 1'b1);
				2: write_all(32'd0, $urandom_range(1, 200), 32'hffff_ffff, 32'hffff_ffff, 1'b1);
				3: write_all($urandom(), $urandom(), $urandom(), 32'd10, 1'b0);
				4: write_all(32'd500, $urandom_range(0, 5000), $urandom(),
					$urandom_range(0, 100), 1'b1);
				default: write_all(32'hffff_ffff, 32'd1, 32'd50, 32'd5, 1'b1);
			endcase
			flow_mode = (p == 0) ? 0 : ((p % 2 == 1) ? 1 : 2);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				pending_reqs.push_back(random_req());
			wait_idle();
		end

		repeat (END_SETTLE) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/rqt_pkg.sv
sv/rqt_cfg.sv
sv/rqt_cpu_ring.sv
sv/rqt_quota.sv
sv/resource_quota_tracker_core.sv
bench/tb.sv
